### rtl/binary_min_heap_queue_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the binary min-heap queue
// Shared concurrent assertion forms, clocked and disabled by reset.
// ----------------------------------------------------------------------------
`ifndef BINARY_MIN_HEAP_QUEUE_ASSERT_SVH
`define BINARY_MIN_HEAP_QUEUE_ASSERT_SVH

// Same-cycle implication
`define BMHQ_ASSERT_IMPLY(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("bmhq: same-cycle check failed");

// Next-cycle implication
`define BMHQ_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("bmhq: next-cycle check failed");

`endif

### rtl/bmhq_pkg.sv
// ----------------------------------------------------------------------------
// bmhq_pkg
// Sizes, codes and shared types of the binary min-heap queue.
// ----------------------------------------------------------------------------
package bmhq_pkg;

  localparam int CAPACITY = 1024;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = ADDR_W + 2;
  localparam int KEY_W    = 32;
  localparam int REQ_W    = 2;
  localparam int STAT_W   = 2;
  localparam int OCC_W    = 11;

  typedef logic signed [KEY_W-1:0] key_t;

  localparam key_t KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH = 2'd0,
    REQ_POP  = 2'd1,
    REQ_PEEK = 2'd2,
    REQ_NOP  = 2'd3
  } req_type_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_UP,
    S_TOP,
    S_DOWN,
    S_FIN,
    S_DONE
  } state_t;

  // Key store access for one cycle
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    key_t              wdata;
    logic [ADDR_W-1:0] raddr_a;
    logic [ADDR_W-1:0] raddr_b;
  } mem_req_t;

endpackage

### rtl/bmhq_if.sv
// ----------------------------------------------------------------------------
// bmhq_req_if / bmhq_rsp_if
// Valid/ready channels for requests and responses of the heap queue.
// ----------------------------------------------------------------------------
interface bmhq_req_if;
  import bmhq_pkg::*;

  logic             valid;
  logic             ready;
  logic [REQ_W-1:0] req_type;
  key_t             key_in;

  modport source (output valid, output req_type, output key_in, input ready);
  modport sink   (input valid, input req_type, input key_in, output ready);
endinterface

interface bmhq_rsp_if;
  import bmhq_pkg::*;

  logic              valid;
  logic              ready;
  key_t              key_out;
  logic [STAT_W-1:0] status;
  logic [OCC_W-1:0]  occupancy;

  modport source (output valid, output key_out, output status, output occupancy,
                  input ready);
  modport sink   (input valid, input key_out, input status, input occupancy,
                  output ready);
endinterface

### rtl/bmhq_ram.sv
// ----------------------------------------------------------------------------
// bmhq_ram
// Generic synchronous RAM: one write port, two read ports, registered reads.
// ----------------------------------------------------------------------------
module bmhq_ram #(
  parameter int  DEPTH = 1024,
  parameter int  WIDTH = 32,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then register both reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

### rtl/bmhq_ctrl.sv
// ----------------------------------------------------------------------------
// bmhq_ctrl
// Sequencer of the heap: takes a request, walks the sift one level per cycle
// against the key store and registers the response.
// ----------------------------------------------------------------------------
module bmhq_ctrl (
  input  logic              clk,
  input  logic              rst,
  bmhq_req_if.sink          req,
  bmhq_rsp_if.source        rsp,
  output bmhq_pkg::mem_req_t mem,
  input  bmhq_pkg::key_t    rdata_a,
  input  bmhq_pkg::key_t    rdata_b
);
  import bmhq_pkg::*;

  state_t            state, state_next;
  logic [CNT_W-1:0]  cnt, cnt_next;
  logic [ADDR_W-1:0] pos, pos_next;
  key_t              key, key_next;
  req_type_t         op, op_next;
  key_t              kout, kout_next;
  status_t           stat, stat_next;

  logic              rsp_valid;
  key_t              rsp_key;
  status_t           rsp_status;
  logic [OCC_W-1:0]  rsp_occ;

  logic              accept;
  logic              full;
  logic              rsp_free;
  logic [ADDR_W-1:0] par;
  logic              up_less;
  logic [IDX_W-1:0]  left_idx;
  logic [IDX_W-1:0]  right_idx;
  logic              pick_right;
  key_t              child_val;
  logic [ADDR_W-1:0] child_pos;
  logic [IDX_W-1:0]  next_left;
  logic              has_child;
  logic              down_less;
  logic [CNT_W-1:0]  cnt_dec;
  logic              pop_has_child;

  function automatic logic [ADDR_W-1:0] parent_of(input logic [ADDR_W-1:0] p);
    logic [ADDR_W-1:0] pm;
    pm = p - 1'b1;
    return pm >> 1;
  endfunction

  assign accept   = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign full     = (cnt == CNT_W'(CAPACITY));
  assign rsp_free = !rsp_valid || rsp.ready;
  assign cnt_dec  = cnt - 1'b1;
  assign pop_has_child = (cnt_dec >= CNT_W'(2));

  // Sift-up decision: held key against its parent
  assign par     = parent_of(pos);
  assign up_less = key < rdata_a;

  // Sift-down decision: smaller child, left on a tie
  assign left_idx   = {1'b0, pos, 1'b1};
  assign right_idx  = left_idx + 1'b1;
  assign pick_right = (right_idx < IDX_W'(cnt)) && (rdata_b < rdata_a);
  assign child_val  = pick_right ? rdata_b : rdata_a;
  assign child_pos  = pick_right ? right_idx[ADDR_W-1:0] : left_idx[ADDR_W-1:0];
  assign next_left  = {1'b0, child_pos, 1'b1};
  assign has_child  = next_left < IDX_W'(cnt);
  assign down_less  = child_val < key;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) state_next = S_START;
      end
      S_START: begin
        unique case (op)
          REQ_PUSH: begin
            if (full || cnt == '0) state_next = S_DONE;
            else                   state_next = S_UP;
          end
          REQ_POP, REQ_PEEK: begin
            if (cnt == '0) state_next = S_DONE;
            else           state_next = S_TOP;
          end
          default: state_next = S_DONE;
        endcase
      end
      S_UP: begin
        if (!up_less)        state_next = S_DONE;
        else if (par == '0)  state_next = S_FIN;
      end
      S_TOP: begin
        if (op == REQ_POP && pop_has_child) state_next = S_DOWN;
        else                                state_next = S_DONE;
      end
      S_DOWN: begin
        if (!down_less)      state_next = S_DONE;
        else if (!has_child) state_next = S_FIN;
      end
      S_FIN:  state_next = S_DONE;
      S_DONE: begin
        if (rsp_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath and key store accesses
  always_comb begin
    cnt_next    = cnt;
    pos_next    = pos;
    key_next    = key;
    op_next     = op;
    kout_next   = kout;
    stat_next   = stat;
    mem         = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          op_next   = req_type_t'(req.req_type);
          key_next  = req.key_in;
          kout_next = '0;
          stat_next = ST_OK;
        end
      end
      S_START: begin
        unique case (op)
          REQ_PUSH: begin
            if (full) begin
              stat_next = ST_FULL;
            end else begin
              cnt_next = cnt + 1'b1;
              pos_next = ADDR_W'(cnt);
              if (cnt == '0) begin
                mem.we    = 1'b1;
                mem.waddr = '0;
                mem.wdata = key;
              end else begin
                mem.raddr_a = parent_of(ADDR_W'(cnt));
              end
            end
          end
          REQ_POP, REQ_PEEK: begin
            if (cnt == '0) begin
              kout_next = KEY_MIN;
              stat_next = ST_EMPTY;
            end else begin
              mem.raddr_a = '0;
              mem.raddr_b = ADDR_W'(cnt_dec);
            end
          end
          default: ;
        endcase
      end
      S_UP: begin
        mem.we = 1'b1;
        if (up_less) begin
          // Move parent down into the hole and climb
          mem.waddr   = pos;
          mem.wdata   = rdata_a;
          pos_next    = par;
          mem.raddr_a = parent_of(par);
        end else begin
          mem.waddr = pos;
          mem.wdata = key;
        end
      end
      S_TOP: begin
        kout_next = rdata_a;
        if (op == REQ_POP) begin
          cnt_next = cnt_dec;
          key_next = rdata_b;
          pos_next = '0;
          if (pop_has_child) begin
            mem.raddr_a = ADDR_W'(1);
            mem.raddr_b = ADDR_W'(2);
          end else begin
            mem.we    = 1'b1;
            mem.waddr = '0;
            mem.wdata = rdata_b;
          end
        end
      end
      S_DOWN: begin
        mem.we = 1'b1;
        if (down_less) begin
          // Move smaller child up into the hole and descend
          mem.waddr   = pos;
          mem.wdata   = child_val;
          pos_next    = child_pos;
          mem.raddr_a = next_left[ADDR_W-1:0];
          mem.raddr_b = ADDR_W'(next_left + 1'b1);
        end else begin
          mem.waddr = pos;
          mem.wdata = key;
        end
      end
      S_FIN: begin
        mem.we    = 1'b1;
        mem.waddr = pos;
        mem.wdata = key;
      end
      S_DONE: ;
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (state == S_DONE && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pos  <= pos_next;
    key  <= key_next;
    op   <= op_next;
    kout <= kout_next;
    stat <= stat_next;
    if (state == S_DONE && rsp_free) begin
      rsp_key    <= kout;
      rsp_status <= stat;
      rsp_occ    <= OCC_W'(cnt);
    end
  end

  assign rsp.valid     = rsp_valid;
  assign rsp.key_out   = rsp_key;
  assign rsp.status    = rsp_status;
  assign rsp.occupancy = rsp_occ;

endmodule

### rtl/binary_min_heap_queue.sv
// ----------------------------------------------------------------------------
// binary_min_heap_queue
// Min-priority queue of signed 32-bit keys kept as a binary heap in one RAM.
//
//   channel  role    payload
//   req      sink    req_type (push/pop/peek), key_in
//   rsp      source  key_out, status, occupancy
//
// One transaction at a time: req is ready only while the sequencer is idle.
// A request's time to its response grows with its sift levels: one key store
// read per level sets the pace. A stalled response holds in its register; the
// next request is taken once the current response has been registered.
// Reset clears the key count, the sequencer state and the response valid; key store contents stay unresolved.
// ----------------------------------------------------------------------------
module binary_min_heap_queue (
  input  logic       clk,
  input  logic       rst,
  bmhq_req_if.sink   req,
  bmhq_rsp_if.source rsp
);
  import bmhq_pkg::*;

  mem_req_t          mem;
  logic [KEY_W-1:0]  rdata_a;
  logic [KEY_W-1:0]  rdata_b;

  // Heap sequencer
  bmhq_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rsp     (rsp),
    .mem     (mem),
    .rdata_a (key_t'(rdata_a)),
    .rdata_b (key_t'(rdata_b))
  );

  // Key store
  bmhq_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (KEY_W)
  ) u_key_store (
    .clk     (clk),
    .we      (mem.we),
    .waddr   (mem.waddr),
    .wdata   (mem.wdata),
    .raddr_a (mem.raddr_a),
    .raddr_b (mem.raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

endmodule

### rtl/bmhq_checker.sv
// ----------------------------------------------------------------------------
// bmhq_checker
// Port-level checks of the heap queue responses, bound to the top level.
// ----------------------------------------------------------------------------
`include "binary_min_heap_queue_assert.svh"

module bmhq_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   req_valid,
  input logic                   req_ready,
  input logic                   rsp_valid,
  input logic                   rsp_ready,
  input bmhq_pkg::key_t         rsp_key_out,
  input logic [bmhq_pkg::STAT_W-1:0] rsp_status,
  input logic [bmhq_pkg::OCC_W-1:0]  rsp_occupancy
);
  import bmhq_pkg::*;

  logic req_fire;
  assign req_fire = req_valid && req_ready;

  // Hold a stalled response
  `BMHQ_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid)

  // Empty responses carry the minimum key and no occupancy
  `BMHQ_ASSERT_IMPLY(a_empty_resp, clk, rst, rsp_valid && rsp_status == ST_EMPTY, rsp_key_out == KEY_MIN && rsp_occupancy == '0)

  // Full responses report a full heap and a zero key
  `BMHQ_ASSERT_IMPLY(a_full_resp, clk, rst, rsp_valid && rsp_status == ST_FULL, rsp_occupancy == OCC_W'(CAPACITY) && rsp_key_out == '0)

  // No response appears in the cycle after a request is taken
  `BMHQ_ASSERT_NEXT(a_no_early_resp, clk, rst, req_fire && !rsp_valid, !rsp_valid)

endmodule

bind binary_min_heap_queue bmhq_checker u_bmhq_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_key_out   (rsp.key_out),
  .rsp_status    (rsp.status),
  .rsp_occupancy (rsp.occupancy)
);

### dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: binary min-heap queue testbench
// Drives push/pop/peek/no-op requests with random idle bursts on both
// channels, predicts each response with a local heap model and checks key,
// status and occupancy of every response in order.
// ----------------------------------------------------------------------------
module tb;
  import bmhq_pkg::*;

  localparam key_t KEY_MAX   = {1'b0, {(KEY_W-1){1'b1}}};
  localparam int   LIMIT_NS  = 3_000_000;
  localparam int   TAIL_CYC  = 24;

  typedef struct packed {
    key_t             key;
    status_t          st;
    logic [OCC_W-1:0] occ;
  } heap_result_t;

  // Heap model plus queue of responses still owed by the block
  class heap_scoreboard;
    key_t         heap_keys [CAPACITY];
    int unsigned  key_total;
    heap_result_t owed_q [$];
    int unsigned  errors;

    function new();
      key_total = 0;
      errors    = 0;
    endfunction

    // Apply one accepted request to the model and queue its response
    function void note_request(req_type_t op, key_t k);
      heap_result_t r;
      int unsigned  pos;
      int unsigned  parent;
      int unsigned  child;
      key_t         tmp;
      r.key = '0;
      r.st  = ST_OK;
      case (op)
        REQ_PUSH: begin
          if (key_total >= CAPACITY) begin
            r.st = ST_FULL;
          end else begin
            heap_keys[key_total] = k;
            pos = key_total;
            key_total++;
            // sift up while strictly below the parent
            while (pos > 0) begin
              parent = (pos - 1) / 2;
              if (!(heap_keys[pos] < heap_keys[parent])) break;
              tmp = heap_keys[pos];
              heap_keys[pos] = heap_keys[parent];
              heap_keys[parent] = tmp;
              pos = parent;
            end
          end
        end
        REQ_POP, REQ_PEEK: begin
          if (key_total == 0) begin
            r.key = KEY_MIN;
            r.st  = ST_EMPTY;
          end else begin
            r.key = heap_keys[0];
            if (op == REQ_POP) begin
              key_total--;
              heap_keys[0] = heap_keys[key_total];
              pos = 0;
              // sift down; left child wins ties, equal child stays put
              while (2 * pos + 1 < key_total) begin
                child = 2 * pos + 1;
                if (child + 1 < key_total && heap_keys[child + 1] < heap_keys[child])
                  child++;
                if (!(heap_keys[child] < heap_keys[pos])) break;
                tmp = heap_keys[pos];
                heap_keys[pos] = heap_keys[child];
                heap_keys[child] = tmp;
                pos = child;
              end
            end
          end
        end
        default: ;
      endcase
      r.occ = OCC_W'(key_total);
      owed_q.push_back(r);
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    // Compare one response against the oldest owed one
    task check_response(key_t k, logic [STAT_W-1:0] st, logic [OCC_W-1:0] occ);
      heap_result_t r;
      if (owed_q.size() == 0) begin
        report($sformatf("unexpected response key=%0d status=%0d occ=%0d", k, st, occ));
      end else begin
        r = owed_q.pop_front();
        if (k !== r.key)
          report($sformatf("key_out %0d, want %0d", k, r.key));
        if (st !== r.st)
          report($sformatf("status %0d, want %0d", st, r.st));
        if (occ !== r.occ)
          report($sformatf("occupancy %0d, want %0d", occ, r.occ));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  logic idle_on;
  int   stall_left;

  heap_scoreboard sb;

  bmhq_req_if req_ch ();
  bmhq_rsp_if rsp_ch ();

  binary_min_heap_queue u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #2 clk = ~clk;

  // Response ready: random stall bursts while idling is on
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      rsp_ch.ready <= 1'b0;
      stall_left   <= $urandom_range(0, 11);
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  // Check every response transaction
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready)
      sb.check_response(rsp_ch.key_out, rsp_ch.status, rsp_ch.occupancy);
  end

  // Mix of extremes, small values (many duplicates) and full-range keys
  function automatic key_t rand_key();
    case ($urandom_range(0, 7))
      0:       return KEY_MIN;
      1:       return KEY_MAX;
      2, 3, 4: return key_t'($urandom_range(0, 15)) - 8;
      default: return key_t'($urandom);
    endcase
  endfunction

  // Pick an operation; peek takes what push and pop leave below 97 percent
  function automatic req_type_t rand_op(int push_pct, int pop_pct);
    int w;
    w = $urandom_range(0, 99);
    if (w < push_pct)                return REQ_PUSH;
    else if (w < push_pct + pop_pct) return REQ_POP;
    else if (w < 97)                 return REQ_PEEK;
    else                             return REQ_NOP;
  endfunction

  // Present one request and hold it until it is accepted
  task automatic send_item(req_type_t op, key_t k);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= op;
    req_ch.key_in   <= k;
    do @(posedge clk); while (!req_ch.ready);
    sb.note_request(op, k);
  endtask

  // Hold off new requests until every owed response has arrived
  task automatic drain_responses();
    req_ch.valid <= 1'b0;
    while (sb.owed_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYC) @(posedge clk);
  endtask

  task automatic send_mixed(int n, int push_pct, int pop_pct);
    repeat (n) send_item(rand_op(push_pct, pop_pct), rand_key());
  endtask

  initial begin
    rst             = 1'b1;
    idle_on         = 1'b1;
    req_ch.valid    = 1'b0;
    req_ch.req_type = REQ_NOP;
    req_ch.key_in   = '0;
    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // empty heap, no-op, extremes, equal keys, then pop past empty
    send_item(REQ_POP, key_t'(32'h1234_5678));
    send_item(REQ_PEEK, '0);
    send_item(REQ_NOP, key_t'(32'hFFFF_FFFF));
    send_item(REQ_PUSH, 5);
    send_item(REQ_PUSH, 5);
    send_item(REQ_PUSH, KEY_MIN);
    send_item(REQ_PUSH, KEY_MAX);
    send_item(REQ_PUSH, 0);
    send_item(REQ_PUSH, -1);
    send_item(REQ_PUSH, 3);
    send_item(REQ_PUSH, 3);
    send_item(REQ_PEEK, KEY_MAX);
    send_item(REQ_NOP, KEY_MIN);
    repeat (9) send_item(REQ_POP, '0);
    send_item(REQ_PEEK, '0);
    drain_responses();

    // random traffic, growing heap
    send_mixed(60, 50, 35);
    drain_responses();

    // fill to capacity, then push onto the full heap
    while (sb.key_total < CAPACITY) send_item(REQ_PUSH, rand_key());
    repeat (6) send_item(REQ_PUSH, rand_key());
    send_item(REQ_PEEK, '0);
    send_item(REQ_NOP, rand_key());

    // deep sift-downs from a large heap
    send_mixed(60, 20, 65);

    // last stretch without idling
    drain_responses();
    idle_on = 1'b0;
    send_mixed(40, 45, 40);

    drain_responses();
    if (sb.errors == 0 && sb.owed_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(LIMIT_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl
rtl/bmhq_pkg.sv
rtl/bmhq_if.sv
rtl/bmhq_ram.sv
rtl/bmhq_ctrl.sv
rtl/binary_min_heap_queue.sv
rtl/bmhq_checker.sv
dv/tb.sv
